// File: sv/rrtt_pkg.sv
// ----------------------------------------------------------------------------
// rrtt_pkg
// Types and codes shared by the round-robin task table files.
// ----------------------------------------------------------------------------
package rrtt_pkg;

  // Operation codes (codes six and seven do nothing)
  localparam logic [2:0] OP_CREATE   = 3'd0;
  localparam logic [2:0] OP_YIELD    = 3'd1;
  localparam logic [2:0] OP_KILL     = 3'd2;
  localparam logic [2:0] OP_COLLECT  = 3'd3;
  localparam logic [2:0] OP_FIND_ID  = 3'd4;
  localparam logic [2:0] OP_FIND_HDL = 3'd5;

  // Task states
  localparam logic [1:0] ST_READY   = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_BLOCKED = 2'd2;
  localparam logic [1:0] ST_DEAD    = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] task_id;
    logic [15:0] handle;
    logic        has_handle;
  } in_item_t;

  typedef struct packed {
    logic [15:0] result_id;
    logic        found;
    logic [1:0]  task_state;
    logic [15:0] result_handle;
    logic        result_has_handle;
    logic        table_full;
  } out_item_t;

  // Write command into the task table (id travels separately)
  typedef struct packed {
    logic        en;
    logic [1:0]  status;
    logic [15:0] handle;
    logic        has_handle;
  } tbl_wr_t;

endpackage

// File: sv/rrtt_table.sv
// ----------------------------------------------------------------------------
// rrtt_table
// Task table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rrtt_table #(
  parameter int TABLE_DEPTH = 16,
  parameter int ID_WIDTH    = 16
) (
  input  logic                           clk,
  input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
  output logic [ID_WIDTH-1:0]            rd_id,
  output logic [1:0]                     rd_status,
  output logic [15:0]                    rd_handle,
  output logic                           rd_has_handle,
  input  rrtt_pkg::tbl_wr_t              wr,
  input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
  input  logic [ID_WIDTH-1:0]            wr_id
);
  import rrtt_pkg::*;

  logic [ID_WIDTH-1:0] id_mem [TABLE_DEPTH];
  logic [1:0]          st_mem [TABLE_DEPTH];
  logic [15:0]         hd_mem [TABLE_DEPTH];
  logic                hh_mem [TABLE_DEPTH];

  // Write entry; id is written only together with a full entry
  always_ff @(posedge clk) begin
    if (wr.en) begin
      id_mem[wr_addr] <= wr_id;
      st_mem[wr_addr] <= wr.status;
      hd_mem[wr_addr] <= wr.handle;
      hh_mem[wr_addr] <= wr.has_handle;
    end
  end

  // Read entry; read data is registered
  always_ff @(posedge clk) begin
    rd_id         <= id_mem[rd_addr];
    rd_status     <= st_mem[rd_addr];
    rd_handle     <= hd_mem[rd_addr];
    rd_has_handle <= hh_mem[rd_addr];
  end

endmodule

// File: sv/round_robin_task_table_core.sv
// ----------------------------------------------------------------------------
// round_robin_task_table_core
// Task table with create, yield, kill, collect and two lookups.
// ----------------------------------------------------------------------------
// Usage: drive in_data and raise start; the transaction is taken when start
// is high and busy is low. Exactly one result per transaction appears on
// out_data for one cycle, marked by out_valid; the receiver cannot stall.
// Create, unused codes and operations on an empty table answer without a scan.
// Lookups and kill scan the table in creation order, one entry per cycle
// through the single read port. Yield reads the current entry then scans
// the rest circularly; demoting the old running task adds a re-read and a
// rewrite of that entry. Collect streams every entry through read and
// compacting write.
// busy stays high until the result is shown. Reset clears the entry count,
// the current task and sets the next id to 1; table memory is not cleared.
// ----------------------------------------------------------------------------
module round_robin_task_table_core #(
  parameter int TABLE_DEPTH = 16,
  parameter int ID_WIDTH    = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rrtt_pkg::in_item_t  in_data,
  output logic                out_valid,
  output rrtt_pkg::out_item_t out_data
);
  import rrtt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int KW = $clog2(TABLE_DEPTH + 2);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_WB   = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [2:0]          op_r, op_nxt;
  logic [15:0]         key_id_r, key_id_nxt;
  logic [15:0]         key_hd_r, key_hd_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [AW-1:0]       cur_r, cur_nxt;
  logic                has_cur_r, has_cur_nxt;
  logic [ID_WIDTH-1:0] next_id_r, next_id_nxt;
  logic [AW-1:0]       iss_addr_r, iss_addr_nxt;
  logic [KW-1:0]       iss_cnt_r, iss_cnt_nxt;
  logic [KW-1:0]       iss_total_r, iss_total_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [AW-1:0]       pend_idx_r, pend_idx_nxt;
  logic                pend_first_r, pend_first_nxt;
  logic                pend_last_r, pend_last_nxt;
  logic                cur_run_r, cur_run_nxt;
  logic [CW-1:0]       w_r, w_nxt;
  logic                keep_r, keep_nxt;
  logic [AW-1:0]       new_cur_r, new_cur_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_r, out_nxt;

  logic [AW-1:0]       rd_addr;
  logic [ID_WIDTH-1:0] rd_id;
  logic [1:0]          rd_status;
  logic [15:0]         rd_handle;
  logic                rd_has_handle;
  tbl_wr_t             wr;
  logic [AW-1:0]       wr_addr;
  logic [ID_WIDTH-1:0] wr_id;

  logic [ID_WIDTH+15:0] rd_id_ext;
  logic [ID_WIDTH+15:0] new_id_ext;
  logic [ID_WIDTH+15:0] key_id_ext;

  assign rd_id_ext  = {16'b0, rd_id};
  assign new_id_ext = {16'b0, next_id_r};
  assign key_id_ext = {{ID_WIDTH{1'b0}}, key_id_r};

  rrtt_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_table (
    .clk           (clk),
    .rd_addr       (rd_addr),
    .rd_id         (rd_id),
    .rd_status     (rd_status),
    .rd_handle     (rd_handle),
    .rd_has_handle (rd_has_handle),
    .wr            (wr),
    .wr_addr       (wr_addr),
    .wr_id         (wr_id)
  );

  // Sequence one operation: accept, scan the table, write back, report
  always_comb begin
    logic          hit;
    logic          yld_ready;
    logic [CW-1:0] w_inc;
    logic          keep_now;
    logic [AW-1:0] new_cur_now;
    logic [CW-1:0] addr_inc;

    state_nxt      = state_r;
    op_nxt         = op_r;
    key_id_nxt     = key_id_r;
    key_hd_nxt     = key_hd_r;
    count_nxt      = count_r;
    cur_nxt        = cur_r;
    has_cur_nxt    = has_cur_r;
    next_id_nxt    = next_id_r;
    iss_addr_nxt   = iss_addr_r;
    iss_cnt_nxt    = iss_cnt_r;
    iss_total_nxt  = iss_total_r;
    pend_v_nxt     = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    pend_first_nxt = pend_first_r;
    pend_last_nxt  = pend_last_r;
    cur_run_nxt    = cur_run_r;
    w_nxt          = w_r;
    keep_nxt       = keep_r;
    new_cur_nxt    = new_cur_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    rd_addr        = iss_addr_r;
    wr             = '0;
    wr_addr        = '0;
    wr_id          = '0;
    hit            = 1'b0;
    yld_ready      = 1'b0;
    w_inc          = w_r + CW'(1);
    keep_now       = keep_r;
    new_cur_now    = new_cur_r;
    addr_inc       = CW'(iss_addr_r) + CW'(1);

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt        = in_data.kind;
          key_id_nxt    = in_data.task_id;
          key_hd_nxt    = in_data.handle;
          out_nxt       = '0;
          iss_cnt_nxt   = '0;
          iss_addr_nxt  = '0;
          iss_total_nxt = KW'(count_r);
          w_nxt         = '0;
          keep_nxt      = 1'b0;
          new_cur_nxt   = '0;
          priority case (1'b1)
            in_data.kind == OP_CREATE: begin
              out_valid_nxt = 1'b1;
              if (count_r == CW'(TABLE_DEPTH)) begin
                out_nxt.table_full = 1'b1;
              end else begin
                wr.en         = 1'b1;
                wr.status     = in_data.has_handle ? ST_READY : ST_BLOCKED;
                wr.handle     = in_data.has_handle ? in_data.handle : 16'd0;
                wr.has_handle = in_data.has_handle;
                wr_addr       = count_r[AW-1:0];
                wr_id         = next_id_r;
                next_id_nxt   = next_id_r + ID_WIDTH'(1);
                count_nxt     = count_r + CW'(1);
                if (count_r == '0) begin
                  has_cur_nxt = 1'b1;
                  cur_nxt     = '0;
                end
                out_nxt.result_id         = new_id_ext[15:0];
                out_nxt.found             = 1'b1;
                out_nxt.task_state        = wr.status;
                out_nxt.result_handle     = wr.handle;
                out_nxt.result_has_handle = in_data.has_handle;
              end
            end
            in_data.kind == OP_YIELD: begin
              if (!has_cur_r || CW'(cur_r) >= count_r) begin
                has_cur_nxt   = 1'b0;
                out_valid_nxt = 1'b1;
              end else begin
                // current entry first, then all entries after it, current last
                iss_addr_nxt  = cur_r;
                iss_total_nxt = KW'(count_r) + KW'(1);
                state_nxt     = S_SCAN;
              end
            end
            in_data.kind == OP_KILL || in_data.kind == OP_FIND_ID ||
            in_data.kind == OP_FIND_HDL || in_data.kind == OP_COLLECT: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                if (in_data.kind == OP_COLLECT) begin
                  has_cur_nxt = 1'b0;
                  cur_nxt     = '0;
                end
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue the next read
        if (iss_cnt_r != iss_total_r) begin
          pend_v_nxt     = 1'b1;
          pend_idx_nxt   = iss_addr_r;
          pend_first_nxt = (iss_cnt_r == '0);
          pend_last_nxt  = (iss_cnt_r + KW'(1) == iss_total_r);
          iss_addr_nxt   = (addr_inc == count_r) ? '0 : addr_inc[AW-1:0];
          iss_cnt_nxt    = iss_cnt_r + KW'(1);
        end
        // Examine returned entry
        if (pend_v_r) begin
          out_nxt = '0;
          priority case (1'b1)
            op_r == OP_YIELD: begin
              if (pend_first_r) begin
                cur_run_nxt = (rd_status == ST_RUNNING);
              end else begin
                yld_ready = (rd_status == ST_READY) ||
                            (pend_idx_r == cur_r && cur_run_r);
                if (yld_ready) begin
                  hit           = 1'b1;
                  wr.en         = 1'b1;
                  wr.status     = ST_RUNNING;
                  wr.handle     = rd_handle;
                  wr.has_handle = rd_has_handle;
                  wr_addr       = pend_idx_r;
                  wr_id         = rd_id;
                  cur_nxt       = pend_idx_r;
                  out_nxt.result_id         = rd_id_ext[15:0];
                  out_nxt.found             = 1'b1;
                  out_nxt.task_state        = ST_RUNNING;
                  out_nxt.result_handle     = rd_handle;
                  out_nxt.result_has_handle = rd_has_handle;
                  if (pend_idx_r != cur_r && cur_run_r) begin
                    // old current still reads running: demote it in S_WB
                    new_cur_nxt = cur_r;
                    state_nxt   = S_WB;
                  end else begin
                    out_valid_nxt = 1'b1;
                    state_nxt     = S_IDLE;
                  end
                end else if (pend_last_r) begin
                  has_cur_nxt   = 1'b0;
                  cur_nxt       = '0;
                  out_valid_nxt = 1'b1;
                  state_nxt     = S_IDLE;
                end
              end
            end
            op_r == OP_COLLECT: begin
              if (rd_status != ST_DEAD) begin
                wr.en         = 1'b1;
                wr.status     = rd_status;
                wr.handle     = rd_handle;
                wr.has_handle = rd_has_handle;
                wr_addr       = w_r[AW-1:0];
                wr_id         = rd_id;
                w_nxt         = w_inc;
                if (has_cur_r && pend_idx_r == cur_r) begin
                  keep_now    = 1'b1;
                  new_cur_now = w_r[AW-1:0];
                end
              end else begin
                w_inc = w_r;
              end
              keep_nxt    = keep_now;
              new_cur_nxt = new_cur_now;
              if (pend_last_r) begin
                count_nxt     = w_inc;
                has_cur_nxt   = keep_now;
                cur_nxt       = keep_now ? new_cur_now : '0;
                out_valid_nxt = 1'b1;
                state_nxt     = S_IDLE;
              end
            end
            default: begin
              // kill and lookups: oldest match wins
              if (op_r == OP_FIND_HDL) begin
                hit = rd_has_handle && (rd_handle == key_hd_r);
              end else begin
                hit = (rd_id_ext == key_id_ext);
              end
              if (hit) begin
                out_nxt.result_id         = rd_id_ext[15:0];
                out_nxt.found             = 1'b1;
                out_nxt.task_state        = rd_status;
                out_nxt.result_handle     = rd_handle;
                out_nxt.result_has_handle = rd_has_handle;
                if (op_r == OP_KILL) begin
                  wr.en              = 1'b1;
                  wr.status          = ST_DEAD;
                  wr.handle          = rd_handle;
                  wr.has_handle      = rd_has_handle;
                  wr_addr            = pend_idx_r;
                  wr_id              = rd_id;
                  out_nxt.task_state = ST_DEAD;
                end
              end
              if (hit || pend_last_r) begin
                out_valid_nxt = 1'b1;
                state_nxt     = S_IDLE;
              end
            end
          endcase
        end
      end

      S_WB: begin
        // Demote the previous current task; its id and handle are re-read
        rd_addr = new_cur_r;
        if (pend_first_r) begin
          wr.en         = 1'b1;
          wr.status     = ST_READY;
          wr.handle     = rd_handle;
          wr.has_handle = rd_has_handle;
          wr_addr       = new_cur_r;
          wr_id         = rd_id;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          pend_first_nxt = 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (state_r == S_SCAN && state_nxt == S_WB) begin
      pend_first_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cur_r       <= '0;
      has_cur_r   <= 1'b0;
      next_id_r   <= ID_WIDTH'(1);
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cur_r       <= cur_nxt;
      has_cur_r   <= has_cur_nxt;
      next_id_r   <= next_id_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_id_r     <= key_id_nxt;
    key_hd_r     <= key_hd_nxt;
    iss_addr_r   <= iss_addr_nxt;
    iss_cnt_r    <= iss_cnt_nxt;
    iss_total_r  <= iss_total_nxt;
    pend_idx_r   <= pend_idx_nxt;
    pend_first_r <= pend_first_nxt;
    pend_last_r  <= pend_last_nxt;
    cur_run_r    <= cur_run_nxt;
    w_r          <= w_nxt;
    keep_r       <= keep_nxt;
    new_cur_r    <= new_cur_nxt;
    out_r        <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: sv/rrtt_chk.sv
// ----------------------------------------------------------------------------
// rrtt_chk
// Port-level checks for the round-robin task table, bound to the top level.
// ----------------------------------------------------------------------------
module rrtt_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input rrtt_pkg::out_item_t out_data
);
  import rrtt_pkg::*;

  // A result is shown only once the block is free again
  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while busy");

  // An accepted transaction is answered at once or keeps the block busy
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("transaction dropped");

  // No result without a transaction in flight
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result without transaction");

  // A refused create reports nothing found
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.table_full) |-> !out_data.found)
    else $error("full table with found");

  // Empty result carries zero fields
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |->
      (out_data.result_id == 16'd0 && out_data.result_handle == 16'd0 &&
       out_data.task_state == ST_READY && !out_data.result_has_handle))
    else $error("nonzero fields on miss");

endmodule

bind round_robin_task_table_core rrtt_chk u_rrtt_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
